// ===== rtl/relocation_break_table_lookup_assert.svh =====
// Assertion macros shared by the relocation break table RTL.
// Expects a clock named clk and an active-low asynchronous reset named arst_n in scope.
`ifndef RELOCATION_BREAK_TABLE_LOOKUP_ASSERT_SVH
`define RELOCATION_BREAK_TABLE_LOOKUP_ASSERT_SVH

// Check that conseq holds in the same cycle as cond.
`define RBT_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Check that conseq holds in the cycle after cond.
`define RBT_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== rtl/rbt_pkg.sv =====
// Shared types and constants for the relocation break table lookup.
// No dependencies; used by the top level relocation_break_table_lookup.
package rbt_pkg;

	localparam int unsigned ADDR_W      = 48;
	localparam int unsigned UNIT_W      = 32;
	localparam int unsigned DISP_W      = 36;
	localparam int unsigned COUNT_W     = 9;
	localparam int unsigned ALIGNMENT   = 16;
	localparam int unsigned ALIGN_SHIFT = $clog2(ALIGNMENT);

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_CMP  = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] object_address;
		logic [ADDR_W-1:0] dest_address;
	} in_t;

	typedef struct packed {
		logic               found;
		logic [DISP_W-1:0]  displacement_bytes;
		logic               append_rejected;
		logic [COUNT_W-1:0] entry_count;
	} out_t;

endpackage

// ===== rtl/rbt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rbt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/relocation_break_table_lookup.sv =====
// Top level of the relocation break table lookup.
// Depends on rbt_pkg, rbt_ram and relocation_break_table_lookup_assert.svh.
//
// Usage:
// - Input channel in_valid / in_stall / in_data carries one command per transfer:
//   clear, append (object_address -> dest_address), lookup, or no operation.
// - Output channel out_valid / out_stall / out_data returns exactly one result per
//   command, in order. out_data is held steady while out_stall is high.
// - cfg_wr_en / cfg_wr_data write the heap base address; write it only while idle.
// - Commands are handled one at a time. After the input transfer, clear, append and
//   no-op go to the done state; a lookup first runs P probes in the compare state, where
//   the probe count P is at most floor(log2(entry_count)) + 1. out_valid rises as the
//   done state ends, and in_stall drops as out_valid rises. The probe loop runs one source
//   RAM read per cycle: the compare of the registered read data picks the next middle
//   entry and issues its read in the same cycle.
// - The output register lets the next command transfer in while a result still
//   waits to be taken; a stalled receiver only holds the next result in the done
//   state, which then keeps in_stall high.
// - Reset clears the entry count, the base address and the output valid. The RAMs are
//   not cleared: entries at or above the count are never read.
module relocation_break_table_lookup #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [rbt_pkg::ADDR_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  rbt_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output rbt_pkg::out_t              out_data
);

	localparam int unsigned AW     = $clog2(TABLE_DEPTH);
	localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned UW     = rbt_pkg::UNIT_W;
	localparam int unsigned DW     = rbt_pkg::DISP_W;
	localparam int unsigned OCW    = rbt_pkg::COUNT_W;
	localparam int unsigned SHIFT  = rbt_pkg::ALIGN_SHIFT;

	// Control state
	rbt_pkg::state_t             state_q, state_d;
	logic [CW-1:0]               count_q;
	logic [rbt_pkg::ADDR_W-1:0]  base_addr_q;
	logic                        out_valid_q;
	rbt_pkg::out_t               out_q;

	// Search window: entries lo_q .. hi1_q-1 are still candidates
	logic [CW-1:0]  lo_q, hi1_q;
	logic [AW-1:0]  mid_q;
	logic [UW-1:0]  idx_q;
	logic [UW-1:0]  dist_q;
	logic           rej_q;

	logic                        accept;
	logic                        out_free;
	logic                        full;
	logic [rbt_pkg::ADDR_W-1:0]  base_off, move_off;
	logic [UW-1:0]               src_units, dist_units;
	logic [UW-1:0]               src_rd, dist_rd;
	logic                        go_left;
	logic [CW-1:0]               win_lo, win_hi1;
	logic [CW:0]                 mid_sum;
	logic [AW-1:0]               mid_n;
	logic                        more;
	logic                        ram_we;
	logic                        found;
	rbt_pkg::out_t               res;
	logic                        st_cmp, st_done, probe_ok;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != rbt_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign full     = (count_q == CW'(TABLE_DEPTH));

	// Convert byte addresses to alignment units, wrapping at 48 bits
	assign base_off   = in_data.object_address - base_addr_q;
	assign move_off   = in_data.object_address - in_data.dest_address;
	assign src_units  = base_off[SHIFT +: UW];
	assign dist_units = move_off[SHIFT +: UW];

	assign ram_we = accept && (in_data.cmd == rbt_pkg::CMD_APPEND) && !full;

	// Narrow the window from the probe just read, or open it on a new lookup
	assign go_left = (idx_q < src_rd);

	always_comb begin
		if (state_q == rbt_pkg::ST_CMP) begin
			win_lo  = go_left ? lo_q : (CW'(mid_q) + CW'(1));
			win_hi1 = go_left ? CW'(mid_q) : hi1_q;
		end else if (accept && (in_data.cmd == rbt_pkg::CMD_LOOKUP)) begin
			win_lo  = '0;
			win_hi1 = count_q;
		end else begin
			win_lo  = '0;
			win_hi1 = '0;
		end
	end

	assign more    = (win_lo < win_hi1);
	assign mid_sum = {1'b0, win_lo} + {1'b0, win_hi1} - (CW+1)'(1);
	assign mid_n   = mid_sum[AW:1];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rbt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = more ? rbt_pkg::ST_CMP : rbt_pkg::ST_DONE;
				end
			end
			rbt_pkg::ST_CMP: begin
				state_d = more ? rbt_pkg::ST_CMP : rbt_pkg::ST_DONE;
			end
			rbt_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = rbt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rbt_pkg::ST_IDLE;
			end
		endcase
	end

	// Result of the finished command; lo_q stays zero for everything but a hit
	assign found = (lo_q != '0);

	always_comb begin
		res.found              = found;
		res.displacement_bytes = found ? DW'({32'b0, dist_q} << SHIFT) : '0;
		res.append_rejected    = rej_q;
		res.entry_count        = OCW'(count_q);
	end

	rbt_ram #(.WIDTH(UW), .DEPTH(TABLE_DEPTH)) u_src_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (src_units),
		.raddr (mid_n),
		.rdata (src_rd)
	);

	rbt_ram #(.WIDTH(UW), .DEPTH(TABLE_DEPTH)) u_dist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (dist_units),
		.raddr (mid_n),
		.rdata (dist_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbt_pkg::ST_IDLE;
			count_q     <= '0;
			base_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				base_addr_q <= cfg_wr_data;
			end
			// Clear empties the table; a non-full append grows it by one
			if (accept && (in_data.cmd == rbt_pkg::CMD_CLEAR)) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == rbt_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= src_units;
			rej_q <= (in_data.cmd == rbt_pkg::CMD_APPEND) && full;
		end
		if (accept || state_q == rbt_pkg::ST_CMP) begin
			lo_q  <= win_lo;
			hi1_q <= win_hi1;
			mid_q <= mid_n;
		end
		// Keep the distance of the last probe at or below the index
		if (state_q == rbt_pkg::ST_CMP && !go_left) begin
			dist_q <= dist_rd;
		end
		if (state_q == rbt_pkg::ST_DONE && out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign st_cmp   = (state_q == rbt_pkg::ST_CMP);
	assign st_done  = (state_q == rbt_pkg::ST_DONE);
	assign probe_ok = (lo_q <= CW'(mid_q)) && (CW'(mid_q) < hi1_q);

`include "relocation_break_table_lookup_assert.svh"

	`RBT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "count above depth")
	`RBT_ASSERT_SAME(a_probe_in_window, st_cmp, probe_ok, "probe outside search window")
	`RBT_ASSERT_SAME(a_reject_when_full, st_done && rej_q, full, "append rejected with room left")
	`RBT_ASSERT_SAME(a_hit_needs_entries, st_done && found, count_q != '0, "hit in empty table")
	`RBT_ASSERT_NEXT(a_probe_exit, st_cmp, st_cmp || st_done, "search left without result")

endmodule
